>>> rtl/ldsr_pkg.sv
// Package for the longest distinct symbol run block: widths, defaults, cell control.
package ldsr_pkg;

    localparam int ALPHABET_DEF = 128;  // presence bits and window cells
    localparam int SYM_IN_W     = 7;    // input symbol width
    localparam int LEN_OUT_W    = 7;    // reported length width
    localparam int LEN_SAT_W    = 9;    // compare width for saturation, holds ALPHABET up to 256
    localparam int SYM_CODES    = 2 ** SYM_IN_W;

    // control broadcast to every window cell
    typedef struct packed {
        logic shift;   // drop oldest: every cell takes its newer neighbor's symbol
        logic append;  // the cell at the window end loads the new symbol
    } t_cell_ctl;

endpackage

>>> rtl/ldsr_if.sv
// Request and result channel interfaces for the longest distinct symbol run block.
interface ldsr_in_if;
    logic                          valid;
    logic                          ready;
    logic [ldsr_pkg::SYM_IN_W-1:0] symbol;
    logic                          final_req;

    modport source (output valid, output symbol, output final_req, input ready);
    modport sink   (input valid, input symbol, input final_req, output ready);
endinterface

interface ldsr_out_if;
    logic                           valid;
    logic                           ready;
    logic [ldsr_pkg::LEN_OUT_W-1:0] window_length;
    logic [ldsr_pkg::LEN_OUT_W-1:0] best_length;
    logic                           done_res;

    modport source (output valid, output window_length, output best_length,
                    output done_res, input ready);
    modport sink   (input valid, input window_length, input best_length,
                    input done_res, output ready);
endinterface

>>> rtl/ldsr_cell.sv
// One window cell: holds one symbol, shifts toward the old end or loads at the window end.
module ldsr_cell #(
    parameter int SW  = 7,
    parameter int LW  = 8,
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  ldsr_pkg::t_cell_ctl i_ctl,
    input  logic [LW-1:0]       i_len,
    input  logic [SW-1:0]       i_sym,
    input  logic [SW-1:0]       i_up_sym,
    output logic [SW-1:0]       o_sym
);
    import ldsr_pkg::*;

    logic [SW-1:0] r_sym;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_sym <= i_up_sym;
        end else if (i_ctl.append && (i_len == LW'(IDX))) begin
            r_sym <= i_sym;
        end
    end

    assign o_sym = r_sym;

endmodule

>>> rtl/longest_distinct_symbol_run_core.sv
// Longest run of distinct symbols: streams a string, reports window and best lengths.
//
// Requests arrive on i_req (valid/ready): one symbol per request, final_req set on
// the string's last symbol. Every request yields one result on o_res carrying the
// length of the repeat-free window ending at that symbol, the longest such length
// so far in the string (both saturate at 127), and done_res = final_req.
// The window is a row of cells, oldest symbol in cell 0. A repeated symbol drops
// the oldest symbol one per cycle, all cells shifting toward cell 0, until the
// repeat has left; the new symbol is then loaded at the window end.
// Steps: a request is registered in r_sym and r_fin; the walk state then drops
// symbols as above and appends, and the result is in the output register after that.
// Over a string, each symbol is dropped at most once. A new request is taken once
// the previous one is done.
// A result stalled on o_res.ready holds the output register; the next request is
// still accepted and worked on, finishing when the register frees up.
// Reset (synchronous, active low) clears presence bits, lengths and the channels.
// After a final symbol all string state is back to the reset value.
module longest_distinct_symbol_run_core #(
    parameter int ALPHABET = ldsr_pkg::ALPHABET_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ldsr_in_if.sink        i_req,
    ldsr_out_if.source     o_res
);
    import ldsr_pkg::*;

    localparam int SW = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
    localparam int LW = $clog2(ALPHABET + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic                 r_state;
    logic [SW-1:0]        r_sym;
    logic                 r_fin;
    logic [LW-1:0]        r_len;
    logic [LW-1:0]        r_best;
    logic [ALPHABET-1:0]  r_present;

    logic                 r_out_valid;
    logic [LEN_OUT_W-1:0] r_out_wl;
    logic [LEN_OUT_W-1:0] r_out_bl;
    logic                 r_out_done;

    logic [SW-1:0]        w_mod_tbl [SYM_CODES];
    logic [SW-1:0]        w_cell_sym [ALPHABET];
    logic                 w_accept;
    logic                 w_hit;
    logic                 w_drop;
    logic                 w_out_free;
    logic                 w_append;
    logic [LW-1:0]        n_len;
    logic [LW-1:0]        n_best;
    t_cell_ctl            w_ctl;

    // symbol reduced modulo the alphabet size
    for (genvar g = 0; g < SYM_CODES; g++) begin : g_mod
        assign w_mod_tbl[g] = SW'(g % ALPHABET);
    end

    assign w_accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign w_hit      = r_present[r_sym];
    assign w_drop     = (r_state == S_WALK) && w_hit && (r_len != '0);
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_append   = (r_state == S_WALK) && !w_drop && w_out_free;

    assign n_len  = r_len + LW'(1);
    assign n_best = (n_len > r_best) ? n_len : r_best;

    assign w_ctl.shift  = w_drop;
    assign w_ctl.append = w_append;

    for (genvar c = 0; c < ALPHABET; c++) begin : g_cell
        logic [SW-1:0] w_up;
        if (c < ALPHABET - 1) begin : g_mid
            assign w_up = w_cell_sym[c + 1];
        end else begin : g_top
            assign w_up = '0;
        end
        ldsr_cell #(
            .SW  (SW),
            .LW  (LW),
            .IDX (c)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_len    (r_len),
            .i_sym    (r_sym),
            .i_up_sym (w_up),
            .o_sym    (w_cell_sym[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_best    <= '0;
            r_present <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (w_drop) begin
                        r_present[w_cell_sym[0]] <= 1'b0;
                        r_len                    <= r_len - LW'(1);
                    end else if (w_append) begin
                        r_state <= S_IDLE;
                        if (r_fin) begin
                            r_present <= '0;
                            r_len     <= '0;
                            r_best    <= '0;
                        end else begin
                            r_present[r_sym] <= 1'b1;
                            r_len            <= n_len;
                            r_best           <= n_best;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sym <= w_mod_tbl[i_req.symbol];
            r_fin <= i_req.final_req;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_append) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_append) begin
            r_out_wl   <= (LEN_SAT_W'(n_len) > LEN_SAT_W'(127)) ? LEN_OUT_W'(127)
                                                                 : LEN_OUT_W'(n_len);
            r_out_bl   <= (LEN_SAT_W'(n_best) > LEN_SAT_W'(127)) ? LEN_OUT_W'(127)
                                                                  : LEN_OUT_W'(n_best);
            r_out_done <= r_fin;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.window_length = r_out_wl;
    assign o_res.best_length   = r_out_bl;
    assign o_res.done_res      = r_out_done;

`ifndef NO_ASSERTIONS
    // every symbol in the window has exactly one presence bit
    a_present_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_present) == 32'(r_len))
        else $error("presence bits disagree with window length");

    // a repeated symbol is always found inside a nonempty window
    a_hit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && w_hit) |-> (r_len != '0))
        else $error("repeat seen with empty window");

    // completing a request always leaves a result in the output register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_append |=> r_out_valid)
        else $error("result not loaded");

    // a final symbol leaves the string state cleared
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_append && r_fin) |=> (r_len == '0 && r_best == '0 && r_present == '0))
        else $error("state not cleared after final symbol");
`endif

endmodule
